### rtl/esc_pkg.sv
// Package: shared types and constants of the escape deframer.
package esc_pkg;

    localparam logic [7:0]  StartByte     = 8'h30;
    localparam logic [7:0]  EndByte       = 8'h03;
    localparam logic [7:0]  EscByte       = 8'h7E;
    localparam logic [15:0] MaxLengthRst  = 16'd256;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_BODY    = 2'd1,
        PH_ESC     = 2'd2,
        PH_DISCARD = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ST_NONE     = 2'd0,
        ST_DONE     = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_NO_END   = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_buffer;
    } t_beat;

    typedef struct packed {
        logic [7:0]  data_out;
        logic        data_valid;
        t_status     status;
        logic [15:0] frame_length;
    } t_result;

    typedef struct packed {
        logic   take;
        logic   emit;
        t_phase phase;
    } t_dec_ctl;

endpackage

### rtl/esc_if.sv
// Interfaces: input byte channel and result channel.
interface esc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       end_of_buffer;

    modport source(output valid, output rx_byte, output end_of_buffer, input ready);
    modport sink(input valid, input rx_byte, input end_of_buffer, output ready);
endinterface

interface esc_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_out;
    logic        data_valid;
    logic [1:0]  status;
    logic [15:0] frame_length;

    modport source(output valid, output data_out, output data_valid, output status,
                   output frame_length, input ready);
    modport sink(input valid, input data_out, input data_valid, input status,
                 input frame_length, output ready);
endinterface

### rtl/esc_in_stage.sv
// Input register: captures one received beat for the decoder.
module esc_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  esc_pkg::t_beat i_beat,
    input  logic           i_take,
    output logic           o_ready,
    output logic           o_valid,
    output esc_pkg::t_beat o_beat
);

    logic           r_valid;
    logic           n_valid;
    esc_pkg::t_beat r_beat;

    assign o_ready = !r_valid || i_take;

    always_comb begin
        n_valid = r_valid;
        if (i_valid && o_ready) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_beat <= i_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

### rtl/esc_decode.sv
// Decoder: frame state, length count, limit register and per-beat decision.
module esc_decode (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_wdata,
    input  logic              i_valid,
    input  esc_pkg::t_beat    i_beat,
    input  logic              i_out_free,
    output esc_pkg::t_dec_ctl o_ctl,
    output esc_pkg::t_result  o_result
);

    esc_pkg::t_phase  r_phase;
    esc_pkg::t_phase  n_phase;
    logic [15:0]      r_count;
    logic [15:0]      n_count;
    logic [15:0]      r_max_length;
    logic             emit;
    logic             take;
    esc_pkg::t_result res;
    logic [7:0]       b;
    logic             eob;

    assign b   = i_beat.rx_byte;
    assign eob = i_beat.end_of_buffer;

    // next state
    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        case (r_phase)
            esc_pkg::PH_HUNT: begin
                if (eob) begin
                    n_phase = esc_pkg::PH_HUNT;
                    n_count = 16'd0;
                end else if (b == esc_pkg::StartByte) begin
                    n_phase = esc_pkg::PH_BODY;
                    n_count = 16'd0;
                end
            end
            esc_pkg::PH_BODY: begin
                if (b == esc_pkg::EndByte || r_count >= r_max_length) begin
                    n_phase = eob ? esc_pkg::PH_HUNT : esc_pkg::PH_DISCARD;
                    n_count = 16'd0;
                end else if (b == esc_pkg::EscByte || b == esc_pkg::StartByte) begin
                    if (eob) begin
                        n_phase = esc_pkg::PH_HUNT;
                        n_count = 16'd0;
                    end else begin
                        n_phase = esc_pkg::PH_ESC;
                    end
                end else if (eob) begin
                    n_phase = esc_pkg::PH_HUNT;
                    n_count = 16'd0;
                end else begin
                    n_count = r_count + 16'd1;
                end
            end
            esc_pkg::PH_ESC: begin
                if (eob) begin
                    n_phase = esc_pkg::PH_HUNT;
                    n_count = 16'd0;
                end else begin
                    n_phase = esc_pkg::PH_BODY;
                    n_count = r_count + 16'd1;
                end
            end
            esc_pkg::PH_DISCARD: begin
                if (eob) begin
                    n_phase = esc_pkg::PH_HUNT;
                    n_count = 16'd0;
                end
            end
            default: begin
                n_phase = esc_pkg::PH_HUNT;
                n_count = 16'd0;
            end
        endcase
    end

    // result
    always_comb begin
        emit             = 1'b0;
        res.data_out     = 8'd0;
        res.data_valid   = 1'b0;
        res.status       = esc_pkg::ST_NONE;
        res.frame_length = 16'd0;
        case (r_phase)
            esc_pkg::PH_HUNT: begin
                if (eob) begin
                    emit       = 1'b1;
                    res.status = esc_pkg::ST_NO_END;
                end
            end
            esc_pkg::PH_BODY: begin
                if (b == esc_pkg::EndByte) begin
                    emit             = 1'b1;
                    res.status       = esc_pkg::ST_DONE;
                    res.frame_length = r_count;
                end else if (r_count >= r_max_length) begin
                    emit       = 1'b1;
                    res.status = esc_pkg::ST_OVERFLOW;
                end else if (b == esc_pkg::EscByte || b == esc_pkg::StartByte) begin
                    if (eob) begin
                        emit       = 1'b1;
                        res.status = esc_pkg::ST_NO_END;
                    end
                end else begin
                    emit           = 1'b1;
                    res.data_out   = b;
                    res.data_valid = 1'b1;
                    res.status     = eob ? esc_pkg::ST_NO_END : esc_pkg::ST_NONE;
                end
            end
            esc_pkg::PH_ESC: begin
                emit           = 1'b1;
                res.data_out   = b ^ esc_pkg::EscByte;
                res.data_valid = 1'b1;
                res.status     = eob ? esc_pkg::ST_NO_END : esc_pkg::ST_NONE;
            end
            esc_pkg::PH_DISCARD: begin
                emit = 1'b0;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    // advance when the beat either gives nothing or finds the result slot free
    assign take = i_valid && (!emit || i_out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= esc_pkg::PH_HUNT;
            r_count      <= 16'd0;
            r_max_length <= esc_pkg::MaxLengthRst;
        end else begin
            if (take) begin
                r_phase <= n_phase;
                r_count <= n_count;
            end
            if (i_cfg_we) begin
                r_max_length <= i_cfg_wdata;
            end
        end
    end

    assign o_ctl.take  = take;
    assign o_ctl.emit  = emit;
    assign o_ctl.phase = r_phase;
    assign o_result    = res;

endmodule

### rtl/esc_out_stage.sv
// Result register: holds one decoded beat until the sink takes it.
module esc_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  esc_pkg::t_result i_result,
    input  logic             i_ready,
    output logic             o_free,
    output logic             o_valid,
    output esc_pkg::t_result o_result
);

    logic             r_valid;
    logic             n_valid;
    esc_pkg::t_result r_result;

    assign o_free = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

### rtl/escape_deframer.sv
// Top level: byte-stuffing deframer with XOR escape, one beat per cycle.
// Received bytes enter an input register, are decoded by a combinational frame
// decision, and any result lands in an output register; the block takes one
// byte every cycle except while a stalled sink holds a result pending.
// Bytes that give no result (hunted bytes, accepted escapes, discarded bytes)
// never occupy the output register, so they advance even while a result
// waits. Throughput drops below one byte per cycle only while the sink holds
// ready low with a result pending. max_length is written through
// i_cfg_we/i_cfg_wdata and resets to 256.
module escape_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    esc_in_if.sink      i_in,
    esc_out_if.source   o_out
);

    esc_pkg::t_beat    in_beat;
    esc_pkg::t_beat    stg_beat;
    logic              stg_valid;
    logic              out_free;
    logic              out_valid;
    esc_pkg::t_dec_ctl ctl;
    esc_pkg::t_result  dec_result;
    esc_pkg::t_result  out_result;

    assign in_beat.rx_byte       = i_in.rx_byte;
    assign in_beat.end_of_buffer = i_in.end_of_buffer;

    esc_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_beat  (in_beat),
        .i_take  (ctl.take),
        .o_ready (i_in.ready),
        .o_valid (stg_valid),
        .o_beat  (stg_beat)
    );

    esc_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (stg_valid),
        .i_beat      (stg_beat),
        .i_out_free  (out_free),
        .o_ctl       (ctl),
        .o_result    (dec_result)
    );

    esc_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (ctl.take && ctl.emit),
        .i_result (dec_result),
        .i_ready  (o_out.ready),
        .o_free   (out_free),
        .o_valid  (out_valid),
        .o_result (out_result)
    );

    assign o_out.valid        = out_valid;
    assign o_out.data_out     = out_result.data_out;
    assign o_out.data_valid   = out_result.data_valid;
    assign o_out.status       = out_result.status;
    assign o_out.frame_length = out_result.frame_length;

`ifndef SYNTH
    a_esc_gives_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl.take && ctl.phase == esc_pkg::PH_ESC) |=> (o_out.valid && o_out.data_valid))
        else $error("escaped byte did not produce data");

    a_emit_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl.take && ctl.emit) |=> o_out.valid)
        else $error("result lost on its way to the output register");

    a_done_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status == esc_pkg::ST_DONE) |-> !o_out.data_valid)
        else $error("frame complete carries data");

    a_discard_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl.phase == esc_pkg::PH_DISCARD || ctl.phase == esc_pkg::PH_HUNT
         && !stg_beat.end_of_buffer) |-> !ctl.emit)
        else $error("quiet beat produced a result");
`endif

endmodule
